// ----- rtl/ffea_pkg.sv -----
//------------------------------------------------------------------------------
// ffea_pkg
// Shared types, sizes and status codes of the first-fit extent allocator.
//------------------------------------------------------------------------------
`default_nettype none
package ffea_pkg;
    localparam int FREE_SLOTS = 16;
    localparam int USED_SLOTS = 32;
    localparam int ADDR_BITS  = 32;
    localparam int FIDX_W     = $clog2(FREE_SLOTS);
    localparam int FCNT_W     = $clog2(FREE_SLOTS + 1);
    localparam int UIDX_W     = $clog2(USED_SLOTS);
    localparam int UCNT_W     = $clog2(USED_SLOTS + 1);

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [31:0]          word_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        REG_HEAP_BASE   = 1'd0,
        REG_HEAP_LENGTH = 1'd1
    } reg_idx_t;

    // Operation broadcast to every cell of the free extent chain.
    typedef enum logic [2:0] {
        FOP_HOLD,
        FOP_LOAD,     // load cell from left neighbor (insert / shift right)
        FOP_PULL,     // load cell from right neighbor (remove / shift left)
        FOP_WRITE,    // write the selected cell with broadcast data
        FOP_RESTART   // cell 0 takes the heap extent
    } fop_t;

    typedef struct packed {
        fop_t                  op;
        logic [FIDX_W-1:0]     sel;     // selected cell
        addr_t                 wr_start;
        addr_t                 wr_len;
        addr_t                 rs_start;
        addr_t                 rs_len;
    } fctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_SCAN,
        S_A_USCAN,
        S_A_REMOVE,
        S_R_USCAN,
        S_R_FSCAN,
        S_R_INSERT,
        S_R_REMOVE,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

// ----- rtl/first_fit_extent_allocator_top.sv -----
//------------------------------------------------------------------------------
// first_fit_extent_allocator_top
// First-fit allocator over one address range with release and coalescing.
//------------------------------------------------------------------------------
// One transaction in, one result out. An allocate scans the free extent chain
// one cell per cycle until the first fit, then scans the used table one slot
// per cycle for a free slot, and a removal shifts the cells from the fitted
// one onward toward the head of the chain. A release scans the used table,
// then the free chain for its insertion point, then inserts, merges or
// removes. One transaction is worked on at a time; the result sits in an
// output register and the next transaction is taken as soon as it is
// delivered. Writing heap_base or heap_length restarts the free chain as one
// extent and clears every used slot valid bit in the same cycle.
//------------------------------------------------------------------------------
`default_nettype none
module first_fit_extent_allocator_top (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_we,
    input  wire logic                    cfg_index,
    input  wire logic [31:0]             cfg_wdata,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_mode,
    input  wire logic [31:0]             s_req_size,
    input  wire logic [31:0]             s_req_addr,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [31:0]                  m_grant_addr,
    output logic [1:0]                   m_status
);
    import ffea_pkg::*;

    state_t state_reg, state_next;
    addr_t  base_reg, len_reg;
    logic [FCNT_W-1:0] fcnt_reg, fcnt_next;
    logic [FCNT_W-1:0] fi_reg, fi_next;      // free chain scan index
    logic [UCNT_W-1:0] ui_reg, ui_next;      // used table scan index
    logic              mode_reg;
    addr_t             size_reg, addr_reg, rlen_reg, rlen_next;
    logic [UIDX_W-1:0] slot_reg, slot_next;
    logic [31:0]       grant_reg, grant_next;
    status_t           stat_reg, stat_next;

    logic  uvalid_reg [USED_SLOTS];
    addr_t ustart_mem [USED_SLOTS];
    addr_t ulen_mem   [USED_SLOTS];
    addr_t ustart_q, ulen_q;

    fctl_t ctl;
    fctl_t ctl_mux;
    addr_t f_start, f_len, p_start, p_len;
    logic  cfg_hit;

    assign cfg_hit = cfg_we;

    ffea_chain u_chain (
        .aclk     (aclk),
        .ctl      (ctl_mux),
        .rd_idx   (fi_reg[FIDX_W-1:0]),
        .rd_start (f_start),
        .rd_len   (f_len),
        .rd1_start(p_start),
        .rd1_len  (p_len)
    );

    // Used table: memory with registered read, addressed by the scan index.
    // A grant lands in the slot the scan is looking at.
    logic [UIDX_W-1:0] u_rd_addr;
    logic [UIDX_W-1:0] u_wr_slot;
    logic              u_we, u_clr;
    assign u_rd_addr = ui_next[UIDX_W-1:0];
    assign u_wr_slot = ui_reg[UIDX_W-1:0];
    always_ff @(posedge aclk) begin
        ustart_q <= ustart_mem[u_rd_addr];
        ulen_q   <= ulen_mem[u_rd_addr];
        if (u_we) begin
            ustart_mem[u_wr_slot] <= f_start;
            ulen_mem[u_wr_slot]   <= size_reg;
        end
    end

    // Used valid bits, one flop per slot; reset and config clear all.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < USED_SLOTS; i++) begin
            if (!aresetn || cfg_hit) begin
                uvalid_reg[i] <= 1'b0;
            end else if (u_we && u_wr_slot == UIDX_W'(i)) begin
                uvalid_reg[i] <= 1'b1;
            end else if (u_clr && slot_reg == UIDX_W'(i)) begin
                uvalid_reg[i] <= 1'b0;
            end
        end
    end

    // Scan aids.
    logic  f_end, u_end, uv_cur;
    logic  [UIDX_W-1:0] ui_cur;
    addr_t prev_end, rel_end;
    logic  touch_prev, touch_next;
    assign f_end    = (fi_reg >= fcnt_reg);
    assign u_end    = (ui_reg == UCNT_W'(USED_SLOTS));
    assign ui_cur   = ui_reg[UIDX_W-1:0];
    assign uv_cur   = u_end ? 1'b0 : uvalid_reg[ui_cur];
    assign prev_end = p_start + p_len;
    assign rel_end  = addr_reg + rlen_reg;
    assign touch_prev = (fi_reg != '0) && (prev_end == addr_reg);
    assign touch_next = !f_end && (rel_end == f_start);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_mode) begin
                        state_next = S_R_USCAN;
                    end else if (s_req_size == '0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_A_SCAN;
                    end
                end
            end
            S_A_SCAN: begin
                if (f_end) begin
                    state_next = S_DONE;
                end else if (f_len >= size_reg) begin
                    state_next = S_A_USCAN;
                end
            end
            S_A_USCAN: begin
                if (u_end || !uv_cur) begin
                    state_next = (!u_end && size_reg == f_len) ? S_A_REMOVE : S_DONE;
                end
            end
            S_A_REMOVE: state_next = S_DONE;
            S_R_USCAN: begin
                if (u_end) begin
                    state_next = S_DONE;
                end else if (uv_cur && ustart_q == addr_reg) begin
                    state_next = S_R_FSCAN;
                end
            end
            S_R_FSCAN: begin
                if (f_end || f_start > addr_reg) begin
                    state_next = (touch_prev && touch_next) ? S_R_REMOVE : S_R_INSERT;
                end
            end
            S_R_INSERT: state_next = S_DONE;
            S_R_REMOVE: state_next = S_DONE;
            S_DONE: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        fcnt_next  = fcnt_reg;
        fi_next    = fi_reg;
        ui_next    = ui_reg;
        rlen_next  = rlen_reg;
        slot_next  = slot_reg;
        grant_next = grant_reg;
        stat_next  = stat_reg;
        u_we       = 1'b0;
        u_clr      = 1'b0;
        ctl        = '{op: FOP_HOLD, sel: fi_reg[FIDX_W-1:0], wr_start: f_start,
                       wr_len: f_len, rs_start: base_reg, rs_len: len_reg};
        unique case (state_reg)
            S_IDLE: begin
                fi_next    = '0;
                ui_next    = '0;
                grant_next = '0;
                stat_next  = ST_NOFIT;
            end
            S_A_SCAN: begin
                if (!f_end) begin
                    if (f_len < size_reg) begin
                        fi_next = fi_reg + 1'b1;
                    end
                end
            end
            S_A_USCAN: begin
                if (u_end) begin
                    stat_next = ST_FULL;
                end else if (!uv_cur) begin
                    slot_next  = ui_cur;
                    stat_next  = ST_OK;
                    grant_next = 32'(f_start);
                    u_we       = 1'b1;
                    if (size_reg != f_len) begin
                        ctl.op       = FOP_WRITE;
                        ctl.wr_start = f_start + size_reg;
                        ctl.wr_len   = f_len - size_reg;
                    end
                end else begin
                    ui_next = ui_reg + 1'b1;
                end
            end
            S_A_REMOVE: begin
                ctl.op    = FOP_PULL;
                fcnt_next = fcnt_reg - 1'b1;
            end
            S_R_USCAN: begin
                if (u_end) begin
                    stat_next = ST_UNKNOWN;
                end else if (uv_cur && ustart_q == addr_reg) begin
                    slot_next = ui_cur;
                    rlen_next = ulen_q;
                end else begin
                    ui_next = ui_reg + 1'b1;
                end
            end
            S_R_FSCAN: begin
                if (!(f_end || f_start > addr_reg)) begin
                    fi_next = fi_reg + 1'b1;
                end
            end
            S_R_INSERT: begin
                stat_next = ST_OK;
                u_clr     = 1'b1;
                if (touch_prev) begin
                    ctl.op       = FOP_WRITE;
                    ctl.sel      = fi_reg[FIDX_W-1:0] - 1'b1;
                    ctl.wr_start = p_start;
                    ctl.wr_len   = p_len + rlen_reg;
                end else if (touch_next) begin
                    ctl.op       = FOP_WRITE;
                    ctl.wr_start = addr_reg;
                    ctl.wr_len   = f_len + rlen_reg;
                end else if (fcnt_reg >= FCNT_W'(FREE_SLOTS)) begin
                    stat_next = ST_FULL;
                    u_clr     = 1'b0;
                end else begin
                    ctl.op       = FOP_LOAD;
                    ctl.wr_start = addr_reg;
                    ctl.wr_len   = rlen_reg;
                    fcnt_next    = fcnt_reg + 1'b1;
                end
            end
            S_R_REMOVE: begin
                // Merge both sides into the previous cell, then drop the next.
                // Done as write-previous on the R_FSCAN exit and pull at the current index.
                stat_next = ST_OK;
                u_clr     = 1'b1;
                ctl.op    = FOP_PULL;
                fcnt_next = fcnt_reg - 1'b1;
            end
            S_DONE: ;
            default: ;
        endcase
        if (cfg_hit) begin
            ctl.op    = FOP_RESTART;
            ctl.rs_start = (cfg_index == REG_HEAP_BASE) ? cfg_wdata : base_reg;
            ctl.rs_len   = (cfg_index == REG_HEAP_LENGTH) ? cfg_wdata : len_reg;
            fcnt_next    = (ctl.rs_len != '0) ? FCNT_W'(1) : '0;
        end
    end

    // The double merge needs two chain writes; the first lands in R_FSCAN exit.
    logic merge_wr;
    assign merge_wr = (state_reg == S_R_FSCAN) && (state_next == S_R_REMOVE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            base_reg  <= '0;
            len_reg   <= '0;
            fcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fcnt_reg  <= fcnt_next;
            if (cfg_hit) begin
                if (cfg_index == REG_HEAP_BASE) begin
                    base_reg <= cfg_wdata;
                end else begin
                    len_reg <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        fi_reg    <= fi_next;
        ui_reg    <= ui_next;
        rlen_reg  <= rlen_next;
        slot_reg  <= slot_next;
        grant_reg <= grant_next;
        stat_reg  <= stat_next;
        if (state_reg == S_IDLE && s_valid) begin
            mode_reg <= s_mode;
            size_reg <= s_req_size;
            addr_reg <= s_req_addr;
        end
    end

    // Side write for the double merge: previous cell takes the full span.
    always_comb begin
        ctl_mux = ctl;
        if (merge_wr && !cfg_hit) begin
            ctl_mux.op       = FOP_WRITE;
            ctl_mux.sel      = fi_reg[FIDX_W-1:0] - 1'b1;
            ctl_mux.wr_start = p_start;
            ctl_mux.wr_len   = p_len + rlen_reg + f_len;
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = (state_reg == S_DONE);
    assign m_grant_addr = grant_reg;
    assign m_status     = stat_reg;

    // Assertions.
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("accept and result overlap");
    a_fcnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= FCNT_W'(FREE_SLOTS)) else $error("free count overflow");
    a_grant_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_grant_addr == '0)
        else $error("grant without success");
    a_mode_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) && !cfg_hit |=> $stable(mode_reg))
        else $error("mode changed mid transaction");
endmodule
`default_nettype wire

// ----- rtl/ffea_cell.sv -----
//------------------------------------------------------------------------------
// ffea_cell
// One free extent slot; shifts toward either neighbor on command.
//------------------------------------------------------------------------------
`default_nettype none
module ffea_cell (
    input  wire logic            aclk,
    input  wire ffea_pkg::fctl_t ctl,
    input  wire logic [ffea_pkg::FIDX_W-1:0] my_idx,
    input  wire ffea_pkg::addr_t left_start,
    input  wire ffea_pkg::addr_t left_len,
    input  wire ffea_pkg::addr_t right_start,
    input  wire ffea_pkg::addr_t right_len,
    output ffea_pkg::addr_t      start_q,
    output ffea_pkg::addr_t      len_q
);
    import ffea_pkg::*;
    addr_t start_reg, len_reg;

    // LOAD shifts the cells beyond the selected one and writes the selected cell; PULL shifts at and beyond it.
    always_ff @(posedge aclk) begin
        case (ctl.op)
            FOP_LOAD: begin
                if (my_idx > ctl.sel) begin
                    start_reg <= left_start;
                    len_reg   <= left_len;
                end else if (my_idx == ctl.sel) begin
                    start_reg <= ctl.wr_start;
                    len_reg   <= ctl.wr_len;
                end
            end
            FOP_PULL: begin
                if (my_idx >= ctl.sel) begin
                    start_reg <= right_start;
                    len_reg   <= right_len;
                end
            end
            FOP_WRITE: begin
                if (my_idx == ctl.sel) begin
                    start_reg <= ctl.wr_start;
                    len_reg   <= ctl.wr_len;
                end
            end
            FOP_RESTART: begin
                if (my_idx == '0) begin
                    start_reg <= ctl.rs_start;
                    len_reg   <= ctl.rs_len;
                end
            end
            default: ;
        endcase
    end
    assign start_q = start_reg;
    assign len_q   = len_reg;
endmodule
`default_nettype wire

// ----- rtl/ffea_chain.sv -----
//------------------------------------------------------------------------------
// ffea_chain
// Row of free extent cells, kept sorted by start address.
//------------------------------------------------------------------------------
`default_nettype none
module ffea_chain (
    input  wire logic            aclk,
    input  wire ffea_pkg::fctl_t ctl,
    input  wire logic [ffea_pkg::FIDX_W-1:0] rd_idx,
    output ffea_pkg::addr_t      rd_start,
    output ffea_pkg::addr_t      rd_len,
    output ffea_pkg::addr_t      rd1_start,
    output ffea_pkg::addr_t      rd1_len
);
    import ffea_pkg::*;
    addr_t st [FREE_SLOTS];
    addr_t ln [FREE_SLOTS];

    for (genvar g = 0; g < FREE_SLOTS; g++) begin : g_cell
        ffea_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .my_idx     (FIDX_W'(g)),
            .left_start (st[(g == 0) ? 0 : g - 1]),
            .left_len   (ln[(g == 0) ? 0 : g - 1]),
            .right_start(st[(g == FREE_SLOTS - 1) ? g : g + 1]),
            .right_len  (ln[(g == FREE_SLOTS - 1) ? g : g + 1]),
            .start_q    (st[g]),
            .len_q      (ln[g])
        );
    end

    // Read port for the scan: the indexed cell and its predecessor.
    logic [FIDX_W-1:0] prev_idx;
    assign prev_idx  = rd_idx - 1'b1;
    assign rd_start  = st[rd_idx];
    assign rd_len    = ln[rd_idx];
    assign rd1_start = st[prev_idx];
    assign rd1_len   = ln[prev_idx];
endmodule
`default_nettype wire

// ----- bench/ffea_checker.sv -----
//------------------------------------------------------------------------------
// ffea_checker
// Watches both channels of the extent allocator, keeps its own copy of the
// free and used tables, predicts every result and compares it field by field.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps
module ffea_checker
    import ffea_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_req_size,
    input  logic [31:0] s_req_addr,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_grant_addr,
    input  logic [1:0]  m_status,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic [31:0] grant;
        status_t     status;
    } outcome_t;

    logic [31:0] base_reg, length_reg;
    logic [31:0] ext_start [FREE_SLOTS+1];
    logic [31:0] ext_len   [FREE_SLOTS+1];
    int          ext_count;
    logic [31:0] blk_start [USED_SLOTS];
    logic [31:0] blk_len   [USED_SLOTS];
    bit          blk_live  [USED_SLOTS];
    outcome_t    awaited [$];

    function automatic void restart_heap();
        ext_start[0] = base_reg;
        ext_len[0]   = length_reg;
        ext_count    = (length_reg != 0) ? 1 : 0;
        for (int i = 0; i < USED_SLOTS; i++) blk_live[i] = 1'b0;
    endfunction

    function automatic void drop_extent(int p);
        for (int i = p; i + 1 < ext_count; i++) begin
            ext_start[i] = ext_start[i+1];
            ext_len[i]   = ext_len[i+1];
        end
        ext_count--;
    endfunction

    function automatic outcome_t allocate_block(logic [31:0] size);
        outcome_t r;
        int fit, slot;
        r = '{grant: '0, status: ST_NOFIT};
        fit = -1;
        slot = -1;
        if (size == 0) return r;
        for (int i = 0; i < ext_count; i++)
            if (fit < 0 && ext_len[i] >= size) fit = i;
        if (fit < 0) return r;
        for (int i = 0; i < USED_SLOTS; i++)
            if (slot < 0 && !blk_live[i]) slot = i;
        if (slot < 0) begin
            r.status = ST_FULL;
            return r;
        end
        r.grant = ext_start[fit];
        r.status = ST_OK;
        blk_start[slot] = ext_start[fit];
        blk_len[slot] = size;
        blk_live[slot] = 1'b1;
        if (size < ext_len[fit]) begin
            ext_start[fit] = ext_start[fit] + size;
            ext_len[fit] = ext_len[fit] - size;
        end else begin
            drop_extent(fit);
        end
        return r;
    endfunction

    function automatic status_t release_block(logic [31:0] addr);
        int slot, p;
        logic [31:0] len;
        bit near_lo, near_hi;
        slot = -1;
        for (int i = 0; i < USED_SLOTS; i++)
            if (slot < 0 && blk_live[i] && blk_start[i] == addr) slot = i;
        if (slot < 0) return ST_UNKNOWN;
        len = blk_len[slot];
        p = ext_count;
        for (int i = ext_count - 1; i >= 0; i--)
            if (ext_start[i] > addr) p = i;
        near_lo = (p > 0) && (ext_start[p-1] + ext_len[p-1] == addr);
        near_hi = (p < ext_count) && (addr + len == ext_start[p]);
        if (near_lo && near_hi) begin
            ext_len[p-1] = ext_len[p-1] + len + ext_len[p];
            drop_extent(p);
        end else if (near_lo) begin
            ext_len[p-1] = ext_len[p-1] + len;
        end else if (near_hi) begin
            ext_start[p] = addr;
            ext_len[p] = ext_len[p] + len;
        end else begin
            if (ext_count >= FREE_SLOTS) return ST_FULL;
            for (int i = ext_count; i > p; i--) begin
                ext_start[i] = ext_start[i-1];
                ext_len[i] = ext_len[i-1];
            end
            ext_start[p] = addr;
            ext_len[p] = len;
            ext_count++;
        end
        blk_live[slot] = 1'b0;
        return ST_OK;
    endfunction

    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            base_reg = '0;
            length_reg = '0;
            restart_heap();
            awaited.delete();
            fail_count = 0;
        end else begin
            // check the result side first; a new request cannot finish this cycle
            if (m_valid && m_ready) begin
                if (awaited.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result grant=%h status=%0d",
                                 m_grant_addr, m_status);
                end else begin
                    want = awaited.pop_front();
                    if (want.grant !== m_grant_addr || want.status !== m_status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: grant exp %h got %h, status exp %0d got %0d",
                                     want.grant, m_grant_addr, want.status, m_status);
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == REG_HEAP_BASE) base_reg = cfg_wdata;
                else length_reg = cfg_wdata;
                restart_heap();
            end
            if (s_valid && s_ready) begin
                if (s_mode == 1'b0) begin
                    awaited.push_back(allocate_block(s_req_size));
                end else begin
                    want.grant = '0;
                    want.status = release_block(s_req_addr);
                    awaited.push_back(want);
                end
            end
        end
        pending = awaited.size();
    end
endmodule

// ----- bench/tb_first_fit_extent_allocator_top.sv -----
//------------------------------------------------------------------------------
// tb_first_fit_extent_allocator_top
// Drives allocate and release transactions into the extent allocator under
// several heap settings, with random idling on both sides, and reports the
// verdict from the checker's failure count.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_first_fit_extent_allocator_top;
    import ffea_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = REG_HEAP_BASE;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_mode = 1'b0;
    logic [31:0] s_req_size = '0;
    logic [31:0] s_req_addr = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_grant_addr;
    logic [1:0]  m_status;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          calm = 1'b0;     // no idling on either side
    bit          hold_off = 1'b0; // receiver long stall
    logic [31:0] granted [$];     // addresses handed out, reused for releases

    always #4 aclk = ~aclk;

    first_fit_extent_allocator_top uut (.*);

    ffea_checker chk (.*);

    // Track grants so that releases mostly hit live blocks.
    always @(posedge aclk)
        if (aresetn && m_valid && m_ready && m_status == ST_OK && m_grant_addr != 0)
            granted.push_back(m_grant_addr);

    // Receiver: random stalls, none while calm, all during the hold-off.
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (hold_off) m_ready <= 1'b0;
        else if (calm) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(99) >= 16);
    end

    // Abort on a hang.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one transaction and hold it until accepted, then drop valid
    // before the next offer.
    task automatic send_request(input logic mode, input logic [31:0] size,
                                input logic [31:0] addr);
        while (!calm && $urandom_range(99) < 16) @(posedge aclk);
        s_valid <= 1'b1;
        s_mode <= mode;
        s_req_size <= size;
        s_req_addr <= addr;
        do @(posedge aclk); while (!s_ready);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Drain, pause past the latency, then write one register.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic pick_release(output logic [31:0] addr);
        int k;
        if (granted.size() != 0 && $urandom_range(9) < 8) begin
            k = $urandom_range(granted.size() - 1);
            addr = granted[k];
            granted.delete(k);
        end else begin
            addr = $urandom;
        end
    endtask

    // Random phase: mostly small sizes so the tables fill and fragment.
    task automatic random_phase(input int count);
        logic [31:0] a;
        logic [31:0] sz;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(1)) begin
                pick_release(a);
                send_request(1'b1, 32'h0, a);
            end else begin
                case ($urandom_range(9))
                    0: sz = $urandom;
                    1: sz = 32'h0;
                    default: sz = $urandom_range(64, 1);
                endcase
                send_request(1'b0, sz, $urandom);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty heap after reset: every allocate misses, releases are unknown.
        send_request(1'b0, 32'd1, 32'h0);
        send_request(1'b1, 32'h0, 32'h0);

        write_reg(REG_HEAP_BASE, 32'h0000_1000);
        write_reg(REG_HEAP_LENGTH, 32'h0000_0400);
        calm = 1'b1;
        send_request(1'b0, 32'h0, 32'h0);           // zero size
        send_request(1'b0, 32'h0000_0800, 32'h0);   // too large
        send_request(1'b0, 32'h100, 32'h0);         // 1000
        send_request(1'b0, 32'h100, 32'h0);         // 1100
        send_request(1'b0, 32'h100, 32'h0);         // 1200
        send_request(1'b1, 32'h0, 32'h0000_1100);   // isolated hole
        send_request(1'b1, 32'h0, 32'h0000_1100);   // unknown now
        send_request(1'b1, 32'h0, 32'h0000_1000);   // merges with next
        send_request(1'b1, 32'h0, 32'h0000_1200);   // merges both sides
        send_request(1'b0, 32'h0000_0400, 32'h0);   // exact whole-extent fit
        send_request(1'b1, 32'h0, 32'h0000_1000);
        calm = 1'b0;

        // Used table full: 33 single-byte grants.
        for (int i = 0; i < 33; i++) send_request(1'b0, 32'd1, 32'h0);
        // Free table full: release every other block, then two addresses past the granted ones.
        while (pending != 0) @(posedge aclk);
        for (int i = 0; i < 36; i += 2) send_request(1'b1, 32'h0, 32'h1000 + i);

        // Range wrapping over the top of the address space, all-ones fields.
        write_reg(REG_HEAP_BASE, 32'hFFFF_FF00);
        write_reg(REG_HEAP_LENGTH, 32'hFFFF_FFFF);
        send_request(1'b0, 32'h0000_0200, 32'hFFFF_FFFF);
        send_request(1'b0, 32'hFFFF_FFFF, 32'h0);
        send_request(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FF00);
        granted.delete();
        random_phase(80);

        // Pressure: stall the receiver while requests keep coming.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            random_phase(20);
        join

        write_reg(REG_HEAP_BASE, 32'h0);
        write_reg(REG_HEAP_LENGTH, 32'h0000_0200);
        granted.delete();
        calm = 1'b1;
        random_phase(100);
        calm = 1'b0;
        random_phase(100);

        write_reg(REG_HEAP_LENGTH, 32'h0);
        granted.delete();
        random_phase(10);
        write_reg(REG_HEAP_BASE, $urandom);
        write_reg(REG_HEAP_LENGTH, 32'h0000_1000);
        granted.delete();
        random_phase(100);

        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
